### hdl/mfsp_pkg.sv
package mfsp_pkg;

    // Longest variable-length quantity accepted, in bytes (1 to 4).
    localparam int VARLEN_MAX_BYTES = 4;

    localparam logic [31:0] HEADER_ID = 32'h4D546864;
    localparam logic [31:0] TRACK_ID  = 32'h4D54726B;
    localparam logic [31:0] HEADER_MIN_LEN = 32'd6;

    localparam int TDATA_W = 136;
    localparam int TUSER_W = 3;

    typedef enum logic [3:0] {
        P_HID, P_HLEN, P_HFMT, P_HNTRK, P_HDIV, P_HSKIP, P_TID, P_TLEN,
        P_DELTA, P_STATUS, P_DATA1, P_DATA2, P_SXLEN, P_MTYPE, P_MLEN, P_PAYLOAD
    } t_phase;

    typedef enum logic [2:0] {
        K_HEADER  = 3'd0,
        K_EVENT   = 3'd1,
        K_SYSEX   = 3'd2,
        K_META    = 3'd3,
        K_PAYLOAD = 3'd4,
        K_ERROR   = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        E_NONE       = 4'd0,
        E_HEADER_ID  = 4'd1,
        E_HEADER_LEN = 4'd2,
        E_FORMAT     = 4'd3,
        E_SMPTE      = 4'd4,
        E_TRACK_ID   = 4'd5,
        E_LONG_VLQ   = 4'd6,
        E_BAD_STATUS = 4'd7,
        E_OVERRUN    = 4'd8,
        E_EARLY_END  = 4'd9
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  status_byte;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic [27:0] delta_time;
        logic [27:0] meta_type;
        logic [27:0] payload_length;
        logic [15:0] track_index;
        t_err        error_code;
        logic        ends_track;
        logic        ends_file;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] word_shift;
        logic [2:0]  field_cnt;
        logic [31:0] skip_left;
        logic [31:0] track_length;
        logic [31:0] bytes_seen;
        logic [15:0] tracks_left;
        logic [15:0] current_track;
        logic [7:0]  running_status;
        logic [7:0]  current_status;
        logic [7:0]  first_data;
        logic [27:0] varlen_accum;
        logic [27:0] delta_held;
        logic [27:0] meta_type_held;
        logic [27:0] payload_left;
        logic        file_format;
    } t_state;

    function automatic logic f_two_data(input logic [7:0] st);
        logic [3:0] hi;
        hi = st[7:4];
        return (hi == 4'h8) || (hi == 4'h9) || (hi == 4'hA) || (hi == 4'hB) ||
               (hi == 4'hE) || (st == 8'hF2);
    endfunction

    function automatic logic f_zero_data(input logic [7:0] st);
        return (st == 8'hF6) || (st == 8'hF8) || (st == 8'hFA) || (st == 8'hFB) ||
               (st == 8'hFC) || (st == 8'hFE);
    endfunction

    function automatic logic f_undefined(input logic [7:0] st);
        return (st[7] == 1'b0) || (st == 8'hF4) || (st == 8'hF5) || (st == 8'hF9) ||
               (st == 8'hFD);
    endfunction

    function automatic t_phase f_after_status(input logic [7:0] st);
        t_phase ph;
        if ((st == 8'hF0) || (st == 8'hF7)) begin
            ph = P_SXLEN;
        end else if (st == 8'hFF) begin
            ph = P_MTYPE;
        end else begin
            ph = P_DATA1;
        end
        return ph;
    endfunction

endpackage

### hdl/mfsp_parser.sv
module mfsp_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_byte,
    input  logic               i_eos,
    output logic               o_res_valid,
    output mfsp_pkg::t_result  o_res
);

    mfsp_pkg::t_state r_state;
    mfsp_pkg::t_state n_state;

    logic [31:0]      ws_sh;
    logic [2:0]       cnt_inc;
    logic [27:0]      vl_acc;
    logic             data_go;
    mfsp_pkg::t_phase data_ph;
    logic             do_finish;
    logic             reprocess;
    mfsp_pkg::t_err   fail_code;
    logic [7:0]       st;
    logic [7:0]       cs;
    logic             hdr_done;
    logic [15:0]      hdr_div;

    always_comb begin
        n_state     = r_state;
        o_res       = '0;
        o_res_valid = 1'b0;
        ws_sh       = {r_state.word_shift[23:0], i_byte};
        cnt_inc     = r_state.field_cnt + 3'd1;
        vl_acc      = {r_state.varlen_accum[20:0], i_byte[6:0]};
        data_go     = 1'b0;
        data_ph     = r_state.phase;
        do_finish   = 1'b0;
        reprocess   = 1'b0;
        fail_code   = mfsp_pkg::E_NONE;
        st          = i_byte[7] ? i_byte : r_state.running_status;
        cs          = r_state.current_status;
        hdr_done    = 1'b0;
        hdr_div     = ws_sh[15:0];

        if (i_eos) begin
            if ((r_state.phase == mfsp_pkg::P_HID) && (r_state.field_cnt == 3'd0)) begin
                n_state = '0;
            end else begin
                fail_code = mfsp_pkg::E_EARLY_END;
            end
        end else begin
            case (r_state.phase)
                mfsp_pkg::P_HID, mfsp_pkg::P_HLEN, mfsp_pkg::P_TID, mfsp_pkg::P_TLEN: begin
                    n_state.word_shift = ws_sh;
                    if (cnt_inc == 3'd4) begin
                        n_state.field_cnt = 3'd0;
                        case (r_state.phase)
                            mfsp_pkg::P_HID: begin
                                if (ws_sh != mfsp_pkg::HEADER_ID) begin
                                    fail_code = mfsp_pkg::E_HEADER_ID;
                                end
                                n_state.phase = mfsp_pkg::P_HLEN;
                            end
                            mfsp_pkg::P_HLEN: begin
                                if (ws_sh < mfsp_pkg::HEADER_MIN_LEN) begin
                                    fail_code = mfsp_pkg::E_HEADER_LEN;
                                end
                                n_state.skip_left = ws_sh - mfsp_pkg::HEADER_MIN_LEN;
                                n_state.phase     = mfsp_pkg::P_HFMT;
                            end
                            mfsp_pkg::P_TID: begin
                                if (ws_sh != mfsp_pkg::TRACK_ID) begin
                                    fail_code = mfsp_pkg::E_TRACK_ID;
                                end
                                n_state.phase = mfsp_pkg::P_TLEN;
                            end
                            default: begin
                                n_state.track_length   = ws_sh;
                                n_state.bytes_seen     = '0;
                                n_state.running_status = '0;
                                n_state.phase          = mfsp_pkg::P_DELTA;
                            end
                        endcase
                    end else begin
                        n_state.field_cnt = cnt_inc;
                    end
                end
                mfsp_pkg::P_HFMT, mfsp_pkg::P_HNTRK, mfsp_pkg::P_HDIV: begin
                    n_state.word_shift = ws_sh;
                    if (cnt_inc == 3'd2) begin
                        n_state.field_cnt = 3'd0;
                        case (r_state.phase)
                            mfsp_pkg::P_HFMT: begin
                                if (ws_sh[15:0] >= 16'd2) begin
                                    fail_code = mfsp_pkg::E_FORMAT;
                                end
                                n_state.file_format = ws_sh[0];
                                n_state.phase       = mfsp_pkg::P_HNTRK;
                            end
                            mfsp_pkg::P_HNTRK: begin
                                n_state.tracks_left = ws_sh[15:0];
                                n_state.phase       = mfsp_pkg::P_HDIV;
                            end
                            default: begin
                                if (ws_sh[15]) begin
                                    fail_code = mfsp_pkg::E_SMPTE;
                                end else if (r_state.skip_left == 32'd0) begin
                                    hdr_done = 1'b1;
                                end else begin
                                    n_state.phase = mfsp_pkg::P_HSKIP;
                                end
                            end
                        endcase
                    end else begin
                        n_state.field_cnt = cnt_inc;
                    end
                end
                mfsp_pkg::P_HSKIP: begin
                    n_state.skip_left = r_state.skip_left - 32'd1;
                    hdr_div           = r_state.word_shift[15:0];
                    if (n_state.skip_left == 32'd0) begin
                        hdr_done = 1'b1;
                    end
                end
                mfsp_pkg::P_STATUS: begin
                    if (mfsp_pkg::f_undefined(st)) begin
                        fail_code = mfsp_pkg::E_BAD_STATUS;
                    end
                    n_state.current_status = st;
                    n_state.running_status = st;
                    cs = st;
                    if (!i_byte[7]) begin
                        // Running status: the byte is data, not a status.
                        if (mfsp_pkg::f_zero_data(st)) begin
                            o_res_valid       = 1'b1;
                            o_res.kind        = mfsp_pkg::K_EVENT;
                            o_res.status_byte = st;
                            o_res.delta_time  = r_state.delta_held;
                            o_res.track_index = r_state.current_track;
                            do_finish         = 1'b1;
                            reprocess         = 1'b1;
                        end else begin
                            data_go = 1'b1;
                            data_ph = mfsp_pkg::f_after_status(st);
                        end
                    end else begin
                        if (r_state.bytes_seen >= r_state.track_length) begin
                            if (fail_code == mfsp_pkg::E_NONE) begin
                                fail_code = mfsp_pkg::E_OVERRUN;
                            end
                        end
                        n_state.bytes_seen = r_state.bytes_seen + 32'd1;
                        if (mfsp_pkg::f_zero_data(st)) begin
                            o_res_valid       = 1'b1;
                            o_res.kind        = mfsp_pkg::K_EVENT;
                            o_res.status_byte = st;
                            o_res.delta_time  = r_state.delta_held;
                            o_res.track_index = r_state.current_track;
                            do_finish         = 1'b1;
                        end else begin
                            n_state.phase = mfsp_pkg::f_after_status(st);
                        end
                    end
                end
                default: begin
                    data_go = 1'b1;
                end
            endcase
        end

        if (hdr_done) begin
            o_res_valid          = 1'b1;
            o_res.kind           = mfsp_pkg::K_HEADER;
            o_res.data_first     = {7'd0, r_state.file_format};
            o_res.payload_length = {12'd0, hdr_div};
            o_res.track_index    = r_state.tracks_left;
            if (r_state.tracks_left == 16'd0) begin
                o_res.ends_file = 1'b1;
                n_state         = '0;
            end else begin
                n_state.phase         = mfsp_pkg::P_TID;
                n_state.current_track = '0;
            end
        end

        if (data_go && (fail_code == mfsp_pkg::E_NONE)) begin
            n_state.phase = data_ph;
            if (r_state.bytes_seen >= r_state.track_length) begin
                fail_code = mfsp_pkg::E_OVERRUN;
            end
            n_state.bytes_seen = r_state.bytes_seen + 32'd1;
            case (data_ph)
                mfsp_pkg::P_DELTA, mfsp_pkg::P_MTYPE, mfsp_pkg::P_SXLEN,
                mfsp_pkg::P_MLEN: begin
                    if (i_byte[7]) begin
                        if (cnt_inc >= 3'(mfsp_pkg::VARLEN_MAX_BYTES)) begin
                            if (fail_code == mfsp_pkg::E_NONE) begin
                                fail_code = mfsp_pkg::E_LONG_VLQ;
                            end
                        end
                        n_state.varlen_accum = vl_acc;
                        n_state.field_cnt    = cnt_inc;
                    end else begin
                        n_state.varlen_accum = '0;
                        n_state.field_cnt    = 3'd0;
                        case (data_ph)
                            mfsp_pkg::P_DELTA: begin
                                n_state.delta_held = vl_acc;
                                n_state.phase      = mfsp_pkg::P_STATUS;
                            end
                            mfsp_pkg::P_MTYPE: begin
                                n_state.meta_type_held = vl_acc;
                                n_state.phase          = mfsp_pkg::P_MLEN;
                            end
                            default: begin
                                n_state.payload_left = vl_acc;
                                o_res_valid          = 1'b1;
                                o_res.status_byte    = cs;
                                o_res.delta_time     = r_state.delta_held;
                                o_res.track_index    = r_state.current_track;
                                o_res.payload_length = vl_acc;
                                if (data_ph == mfsp_pkg::P_MLEN) begin
                                    o_res.kind      = mfsp_pkg::K_META;
                                    o_res.meta_type = r_state.meta_type_held;
                                end else begin
                                    o_res.kind = mfsp_pkg::K_SYSEX;
                                end
                                if (vl_acc == 28'd0) begin
                                    do_finish = 1'b1;
                                end else begin
                                    n_state.phase = mfsp_pkg::P_PAYLOAD;
                                end
                            end
                        endcase
                    end
                end
                mfsp_pkg::P_DATA1: begin
                    if (mfsp_pkg::f_two_data(cs)) begin
                        n_state.first_data = i_byte;
                        n_state.phase      = mfsp_pkg::P_DATA2;
                    end else begin
                        o_res_valid       = 1'b1;
                        o_res.kind        = mfsp_pkg::K_EVENT;
                        o_res.status_byte = cs;
                        o_res.delta_time  = r_state.delta_held;
                        o_res.track_index = r_state.current_track;
                        o_res.data_first  = i_byte;
                        do_finish         = 1'b1;
                    end
                end
                mfsp_pkg::P_DATA2: begin
                    o_res_valid       = 1'b1;
                    o_res.kind        = mfsp_pkg::K_EVENT;
                    o_res.status_byte = cs;
                    o_res.delta_time  = r_state.delta_held;
                    o_res.track_index = r_state.current_track;
                    o_res.data_first  = r_state.first_data;
                    o_res.data_second = i_byte;
                    do_finish         = 1'b1;
                end
                default: begin
                    o_res_valid          = 1'b1;
                    o_res.kind           = mfsp_pkg::K_PAYLOAD;
                    o_res.status_byte    = cs;
                    o_res.data_first     = i_byte;
                    o_res.track_index    = r_state.current_track;
                    n_state.payload_left = r_state.payload_left - 28'd1;
                    if (n_state.payload_left == 28'd0) begin
                        do_finish = 1'b1;
                    end
                end
            endcase
        end

        // End of event: close the track when its byte count is used up.
        if (do_finish) begin
            if (n_state.bytes_seen == r_state.track_length) begin
                o_res.ends_track      = 1'b1;
                n_state.tracks_left   = r_state.tracks_left - 16'd1;
                n_state.current_track = r_state.current_track + 16'd1;
                if (n_state.tracks_left == 16'd0) begin
                    o_res.ends_file = 1'b1;
                    n_state         = '0;
                end else begin
                    n_state.phase = mfsp_pkg::P_TID;
                end
            end else begin
                n_state.phase = mfsp_pkg::P_DELTA;
            end
        end

        // A data byte under a zero-data running status starts what follows.
        if (reprocess) begin
            case (n_state.phase)
                mfsp_pkg::P_DELTA: begin
                    n_state.bytes_seen   = n_state.bytes_seen + 32'd1;
                    n_state.delta_held   = {20'd0, i_byte};
                    n_state.varlen_accum = '0;
                    n_state.field_cnt    = 3'd0;
                    n_state.phase        = mfsp_pkg::P_STATUS;
                end
                default: begin
                    n_state.word_shift = {n_state.word_shift[23:0], i_byte};
                    n_state.field_cnt  = 3'd1;
                end
            endcase
        end

        if (fail_code != mfsp_pkg::E_NONE) begin
            o_res             = '0;
            o_res_valid       = 1'b1;
            o_res.kind        = mfsp_pkg::K_ERROR;
            o_res.error_code  = fail_code;
            o_res.track_index = r_state.current_track;
            n_state           = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/midi_file_stream_parser.sv
// Channel   Dir  Handshake                      Contents
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: file byte; tlast: end of stream
// m_axis    out  m_axis_tvalid / m_axis_tready  tuser: result kind; tdata: event fields;
//                                               tlast: result completes the file
//
// Each file byte is captured in an input register; the parser logic then decodes it
// against the parse state and writes at most one result into the output register.
// The sustained rate is one byte per cycle while the output register is not stalled.
// While the output register holds an untaken result, the input register still takes one
// byte; s_axis_tready drops only when both are full and m_axis_tready is low.
// Reset is synchronous and active low and returns the parser to the header id phase.
module midi_file_stream_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
    input  logic                         s_axis_tlast,   // end_of_stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] status_byte, [15:8] data_first, [23:16] data_second,
    // [51:24] delta_time, [79:52] meta_type, [107:80] payload_length,
    // [123:108] track_index, [127:124] error_code, [128] ends_track, rest zero
    output logic [mfsp_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [mfsp_pkg::TUSER_W-1:0] m_axis_tuser,   // [2:0] kind
    output logic                         m_axis_tlast    // ends_file
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_eos;
    logic              r_out_valid;
    mfsp_pkg::t_result r_out;

    logic              fire;
    logic              res_valid;
    mfsp_pkg::t_result res;

    // The parser consumes the held byte when the output register can take a result.
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    mfsp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .i_eos       (r_in_eos),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_eos  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.ends_file;
    assign m_axis_tdata  = {7'd0, r_out.ends_track, r_out.error_code, r_out.track_index,
                            r_out.payload_length, r_out.meta_type, r_out.delta_time,
                            r_out.data_second, r_out.data_first, r_out.status_byte};

endmodule
